FILE: hdl/nghri_pkg.sv
package nghri_pkg;

    localparam int TOKEN_BITS      = 18;
    localparam int NUM_HEADS       = 16;
    localparam int HEADS_PER_ORDER = 8;
    localparam int END_BITS        = 18;
    localparam int MULT_BITS       = 64;
    localparam int MOD_BITS        = 25;
    localparam int ROW_BITS        = 29;
    localparam int HEAD_BITS       = 4;
    localparam int TABLE_BITS      = 5;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic OP_HASH  = 1'b0;
    localparam logic OP_PRIME = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_END_TOKEN     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_CURRENT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_PREV_ONE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_PREV_TWO = 2'd3;

    localparam logic [END_BITS-1:0]  END_TOKEN_RST     = 18'd248046;
    localparam logic [MULT_BITS-1:0] MULT_CURRENT_RST  = 64'd23703573157769;
    localparam logic [MULT_BITS-1:0] MULT_PREV_ONE_RST = 64'd20109073645365;
    localparam logic [MULT_BITS-1:0] MULT_PREV_TWO_RST = 64'd8052911324071;

    typedef struct packed {
        logic                  op;
        logic                  start_req;
        logic [TOKEN_BITS-1:0] token;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [HEAD_BITS-1:0] head;
        logic                 last;
    } out_item_t;

    function automatic logic [MOD_BITS-1:0] head_modulus(input logic [TABLE_BITS-1:0] h);
        logic [MOD_BITS-1:0] m;
        case (h)
            5'd0:    m = 25'd20000003;
            5'd1:    m = 25'd20000023;
            5'd2:    m = 25'd20000033;
            5'd3:    m = 25'd20000047;
            5'd4:    m = 25'd20000059;
            5'd5:    m = 25'd20000063;
            5'd6:    m = 25'd20000069;
            5'd7:    m = 25'd20000077;
            5'd8:    m = 25'd20000081;
            5'd9:    m = 25'd20000093;
            5'd10:   m = 25'd20000107;
            5'd11:   m = 25'd20000147;
            5'd12:   m = 25'd20000153;
            5'd13:   m = 25'd20000159;
            5'd14:   m = 25'd20000161;
            5'd15:   m = 25'd20000171;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [ROW_BITS-1:0] head_base(input logic [TABLE_BITS-1:0] h);
        logic [ROW_BITS-1:0] b;
        case (h)
            5'd0:    b = 29'd0;
            5'd1:    b = 29'd20000003;
            5'd2:    b = 29'd40000026;
            5'd3:    b = 29'd60000059;
            5'd4:    b = 29'd80000106;
            5'd5:    b = 29'd100000165;
            5'd6:    b = 29'd120000228;
            5'd7:    b = 29'd140000297;
            5'd8:    b = 29'd160000374;
            5'd9:    b = 29'd180000455;
            5'd10:   b = 29'd200000548;
            5'd11:   b = 29'd220000655;
            5'd12:   b = 29'd240000802;
            5'd13:   b = 29'd260000955;
            5'd14:   b = 29'd280001114;
            5'd15:   b = 29'd300001275;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/ngram_hash_row_indexer_top.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_data  (op, start_req, token)
// out     | output    | out_valid/out_stall | out_data (row, head, last)
// cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// A prime item only updates the history and leaves the block idle. A hash
// item runs through the shared 16-bit-slice multiplier (three products of
// four slices), then, for each head in turn, through the radix-16 remainder
// unit and an output transfer. Reset restores the configuration registers
// and fills the history with the end token. in_stall is high from a hash
// item's transfer until its last row transfers.
module ngram_hash_row_indexer_top
#(
    parameter int NUM_HEADS       = nghri_pkg::NUM_HEADS,
    parameter int HEADS_PER_ORDER = nghri_pkg::HEADS_PER_ORDER
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  nghri_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nghri_pkg::out_item_t                out_data,
    input  logic                                cfg_wr_en,
    input  logic [nghri_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [nghri_pkg::MULT_BITS-1:0]     cfg_data
);
    import nghri_pkg::*;

    localparam int HW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam int PP_BITS = TOKEN_BITS + 16;
    localparam int DIV_STEPS = MULT_BITS / 4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]            state_reg;
    logic [END_BITS-1:0]   end_token_reg;
    logic [MULT_BITS-1:0]  mult_cur_reg, mult_p1_reg, mult_p2_reg;
    logic [TOKEN_BITS-1:0] prev1_reg, prev2_reg;
    logic [TOKEN_BITS-1:0] tok_reg, p1_reg, p2_reg;
    logic [1:0]            sel_reg, chunk_reg;
    logic [MULT_BITS-1:0]  prod_reg, bigram_reg, trigram_reg, div_reg;
    logic [MOD_BITS-1:0]   rem_reg;
    logic [3:0]            step_reg;
    logic [HW-1:0]         head_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic                  in_xfer;
    logic [TOKEN_BITS-1:0] p1_eff, p2_pre, p2_eff;
    logic [TOKEN_BITS-1:0] mul_a;
    logic [MULT_BITS-1:0]  mul_b_word;
    logic [15:0]           mul_b;
    logic [PP_BITS-1:0]    pp;
    logic [MULT_BITS-1:0]  prod_next;
    logic [MOD_BITS-1:0]   modulus;
    logic [MOD_BITS-1:0]   rem_next;
    logic [MOD_BITS:0]     t;
    logic [TABLE_BITS-1:0] head_ext;
    logic [HW-1:0]         head_nx;
    logic                  head_last;
    logic [MULT_BITS-1:0]  mix_nx;
    logic [ROW_BITS-1:0]   row_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign p1_eff = in_data.start_req ? TOKEN_BITS'(end_token_reg) : prev1_reg;
    assign p2_pre = in_data.start_req ? TOKEN_BITS'(end_token_reg) : prev2_reg;
    assign p2_eff = (p1_eff == TOKEN_BITS'(end_token_reg)) ? TOKEN_BITS'(end_token_reg)
                                                            : p2_pre;

    always_comb
    begin
        case (sel_reg)
            2'd0:    begin mul_a = tok_reg; mul_b_word = mult_cur_reg; end
            2'd1:    begin mul_a = p1_reg;  mul_b_word = mult_p1_reg;  end
            default: begin mul_a = p2_reg;  mul_b_word = mult_p2_reg;  end
        endcase
        mul_b     = 16'(mul_b_word >> {chunk_reg, 4'b0000});
        pp        = PP_BITS'(mul_a) * PP_BITS'(mul_b);
        prod_next = prod_reg + (MULT_BITS'(pp) << {chunk_reg, 4'b0000});
    end

    assign head_ext    = TABLE_BITS'(head_reg);
    assign modulus     = head_modulus(head_ext);
    assign head_last   = (head_reg == HW'(NUM_HEADS - 1));
    assign head_nx     = head_reg + HW'(1);
    assign mix_nx      = (32'(head_nx) < HEADS_PER_ORDER) ? bigram_reg : trigram_reg;

    always_comb
    begin
        rem_next = rem_reg;
        t = '0;
        for (int i = 0; i < 4; i++)
        begin
            t = {rem_next, div_reg[MULT_BITS-1-i]};
            if (t >= {1'b0, modulus})
                t = t - {1'b0, modulus};
            rem_next = MOD_BITS'(t);
        end
        if (modulus == '0)
            row_val = head_base(head_ext);
        else
            row_val = ROW_BITS'(rem_next) + head_base(head_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_token_reg <= END_TOKEN_RST;
            mult_cur_reg  <= MULT_CURRENT_RST;
            mult_p1_reg   <= MULT_PREV_ONE_RST;
            mult_p2_reg   <= MULT_PREV_TWO_RST;
            prev1_reg     <= TOKEN_BITS'(END_TOKEN_RST);
            prev2_reg     <= TOKEN_BITS'(END_TOKEN_RST);
            sel_reg       <= '0;
            chunk_reg     <= '0;
            step_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_END_TOKEN:     end_token_reg <= END_BITS'(cfg_data);
                    CFG_MULT_CURRENT:  mult_cur_reg  <= cfg_data;
                    CFG_MULT_PREV_ONE: mult_p1_reg   <= cfg_data;
                    CFG_MULT_PREV_TWO: mult_p2_reg   <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        prev2_reg <= p1_eff;
                        prev1_reg <= in_data.token;
                        if (in_data.op == OP_HASH)
                        begin
                            sel_reg   <= '0;
                            chunk_reg <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    chunk_reg <= chunk_reg + 2'd1;
                    if (chunk_reg == 2'd3)
                    begin
                        sel_reg <= sel_reg + 2'd1;
                        if (sel_reg == 2'd2)
                        begin
                            head_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(DIV_STEPS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (head_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            head_reg  <= head_nx;
                            step_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tok_reg  <= in_data.token;
            p1_reg   <= p1_eff;
            p2_reg   <= p2_eff;
            prod_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            if (chunk_reg == 2'd3)
            begin
                prod_reg <= '0;
                case (sel_reg)
                    2'd0:    bigram_reg <= prod_next;
                    2'd1:    bigram_reg <= bigram_reg ^ prod_next;
                    default:
                    begin
                        trigram_reg <= bigram_reg ^ prod_next;
                        div_reg     <= (HEADS_PER_ORDER < 1) ? (bigram_reg ^ prod_next)
                                                             : bigram_reg;
                        rem_reg     <= '0;
                    end
                endcase
            end
            else
                prod_reg <= prod_next;
        end
        if (state_reg == ST_DIV)
        begin
            div_reg <= div_reg << 4;
            rem_reg <= rem_next;
            if (step_reg == 4'(DIV_STEPS - 1))
            begin
                out_reg.row  <= row_val;
                out_reg.head <= HEAD_BITS'(head_ext);
                out_reg.last <= head_last;
            end
        end
        if (state_reg == ST_OUT && !out_stall && !head_last)
        begin
            div_reg <= mix_nx;
            rem_reg <= '0;
        end
    end

endmodule
